// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files; included by interface_association_table.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/iat_pkg.sv =====
// Package with request codes, status codes, register indexes and the entry type of the association table.
`timescale 1ns / 1ps
`default_nettype none
package iat_pkg;
	typedef enum logic [2:0] {
		REQ_ADD = 3'd0,
		REQ_REFRESH = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_REMOVE_NB = 3'd3,
		REQ_RESOLVE = 3'd4,
		REQ_TICK = 3'd5
	} req_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REPLACED = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [2:0] REG_MAIN = 3'd0;
	localparam logic [2:0] REG_IF0 = 3'd1;
	localparam logic [2:0] REG_IF1 = 3'd2;
	localparam logic [2:0] REG_IF2 = 3'd3;
	localparam logic [2:0] REG_IF3 = 3'd4;
	localparam logic [2:0] REG_IFCNT = 3'd5;

	// Payload of one table entry as kept in memory.
	typedef struct packed {
		logic [31:0] iface;
		logic [31:0] main;
		logic [31:0] expiry;
	} entry_t;
endpackage
`default_nettype wire

// ===== rtl/core/interface_association_table.sv =====
// Top level of the interface association table.
// Each request takes two sweeps over the table from acceptance to result, set by the
// single read port of the entry memory.
// One request is in work at a time; the next is accepted once the result is taken.
// arst_n clears the valid bits, the registers and the control; memory content needs no reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module interface_association_table #(
	parameter int TABLE_ENTRIES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic s_tvalid,
	output logic s_tready,
	// tdata: if_address[31:0], node_address[63:32], time_value[95:64]
	input wire logic [95:0] s_tdata,
	// tuser: req_type[2:0]
	input wire logic [2:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// tdata: status[1:0], resolved_addr[33:2], routing_changed[34], next_expiry[66:35],
	// next_valid[67], entry_count[72:68], zero fill[79:73]
	output logic [79:0] m_tdata
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {IDLE, SCAN1, DECIDE, SCAN2, DONE} state_t;

	state_t state_q;
	logic [31:0] main_q, if_q [4];
	logic [2:0] ifcnt_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [2:0] req_q;
	logic [31:0] ia_q, ma_q, tv_q;
	logic [AW-1:0] ra_q, pa_s1;
	logic rd_s1;
	logic hit_q, free_q, last2_q;
	logic [AW-1:0] hit_idx_q, free_idx_q;
	logic [31:0] hit_main_q, mout_q, nexp_q;
	logic nvalid_q, routing_q;
	logic [CW-1:0] cnt_q;
	logic [1:0] status_q;
	logic we;
	logic [AW-1:0] waddr;
	iat_pkg::entry_t wdata, rdata;

	iat_ram #(.WIDTH($bits(iat_pkg::entry_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ra_q), .rdata(rdata)
	);

	// Local interface lookup against the configured list.
	logic local_hit;
	always_comb begin
		local_hit = 1'b0;
		for (int k = 0; k < 4; k++)
			if (k < ((ifcnt_q > 3'd4) ? 3'd4 : ifcnt_q) && if_q[k] == ia_q) local_hit = 1'b1;
	end

	// Per entry result of the second sweep.
	logic rv, rm, rm_nb;
	assign rv = rd_s1 && state_q == SCAN2 && valid_q[pa_s1];
	assign rm_nb = req_q == iat_pkg::REQ_REMOVE_NB && rdata.main == mout_q;
	assign rm = (req_q == iat_pkg::REQ_TICK && rdata.expiry <= tv_q) || rm_nb;

	// Write port: add/refresh in DECIDE.
	always_comb begin
		we = 1'b0;
		waddr = hit_q ? hit_idx_q : free_idx_q;
		wdata = '{iface: ia_q, main: ma_q, expiry: tv_q};
		if (state_q == DECIDE) begin
			if (req_q == iat_pkg::REQ_ADD && (hit_q || free_q)) we = 1'b1;
			if (req_q == iat_pkg::REQ_REFRESH && hit_q) begin
				we = 1'b1;
				wdata.iface = ia_q;
				wdata.main = hit_main_q;
			end
		end
	end

	assign s_tready = state_q == IDLE;
	assign m_tvalid = state_q == DONE;
	assign m_tdata = {7'd0, 5'(cnt_q), nvalid_q, nexp_q, routing_q, mout_q, status_q};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q <= '0;
			if_q <= '{default: '0};
			ifcnt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				iat_pkg::REG_MAIN: main_q <= cfg_data;
				iat_pkg::REG_IF0: if_q[0] <= cfg_data;
				iat_pkg::REG_IF1: if_q[1] <= cfg_data;
				iat_pkg::REG_IF2: if_q[2] <= cfg_data;
				iat_pkg::REG_IF3: if_q[3] <= cfg_data;
				iat_pkg::REG_IFCNT: ifcnt_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Sequencer: sweep one finds hit and free slot, sweep two removes and summarizes.
	// ra_q is the address presented to the memory; pa_s1 is the address whose data
	// is in rdata when rd_s1 is set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			valid_q <= '0;
			ra_q <= '0;
			rd_s1 <= 1'b0;
			last2_q <= 1'b0;
		end else begin
			rd_s1 <= 1'b0;
			case (state_q)
				IDLE: if (s_tvalid) begin
					req_q <= s_tuser;
					ia_q <= s_tdata[31:0];
					ma_q <= s_tdata[63:32];
					tv_q <= s_tdata[95:64];
					hit_q <= 1'b0;
					free_q <= 1'b0;
					ra_q <= '0;
					state_q <= SCAN1;
				end
				SCAN1: begin
					if (rd_s1) begin
						if (valid_q[pa_s1] && rdata.iface == ia_q && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= pa_s1;
							hit_main_q <= rdata.main;
						end
						if (!valid_q[pa_s1] && !free_q) begin
							free_q <= 1'b1;
							free_idx_q <= pa_s1;
						end
					end
					if (rd_s1 && pa_s1 == LAST) state_q <= DECIDE;
					else begin
						ra_q <= ra_q + 1'b1;
						pa_s1 <= ra_q;
						rd_s1 <= 1'b1;
					end
				end
				DECIDE: begin
					status_q <= iat_pkg::ST_OK;
					mout_q <= '0;
					routing_q <= 1'b0;
					case (req_q)
						iat_pkg::REQ_ADD: begin
							if (hit_q) status_q <= iat_pkg::ST_REPLACED;
							else if (free_q) valid_q[free_idx_q] <= 1'b1;
							else status_q <= iat_pkg::ST_FULL;
						end
						iat_pkg::REQ_REFRESH, iat_pkg::REQ_REMOVE: begin
							if (!hit_q) status_q <= iat_pkg::ST_NOT_FOUND;
							else if (req_q == iat_pkg::REQ_REMOVE) valid_q[hit_idx_q] <= 1'b0;
						end
						iat_pkg::REQ_REMOVE_NB, iat_pkg::REQ_RESOLVE: begin
							if (hit_q) mout_q <= hit_main_q;
							else if (local_hit) begin
								mout_q <= main_q;
								status_q <= iat_pkg::ST_REPLACED;
							end else begin
								mout_q <= ia_q;
								status_q <= iat_pkg::ST_NOT_FOUND;
							end
						end
						iat_pkg::REQ_TICK: ;
						default: status_q <= iat_pkg::ST_NOT_FOUND;
					endcase
					nexp_q <= '0;
					nvalid_q <= 1'b0;
					cnt_q <= '0;
					// The second sweep starts reading after the write of this cycle lands.
					ra_q <= '0;
					last2_q <= 1'b0;
					state_q <= SCAN2;
				end
				SCAN2: begin
					if (rv) begin
						if (rm) begin
							valid_q[pa_s1] <= 1'b0;
							routing_q <= 1'b1;
						end else begin
							if (!nvalid_q || rdata.expiry < nexp_q) nexp_q <= rdata.expiry;
							nvalid_q <= 1'b1;
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (rd_s1 && pa_s1 == LAST) last2_q <= 1'b1;
					else if (!last2_q) begin
						ra_q <= ra_q + 1'b1;
						pa_s1 <= ra_q;
						rd_s1 <= 1'b1;
					end
					if (last2_q) begin
						if (req_q == iat_pkg::REQ_REMOVE_NB)
							status_q <= routing_q ? iat_pkg::ST_OK : iat_pkg::ST_NOT_FOUND;
						state_q <= DONE;
					end
				end
				DONE: if (m_tready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, m_tvalid && cnt_q > CW'(TABLE_ENTRIES))
	`ASSERT_NEVER(a_nvalid, clk, arst_n, m_tvalid && (nvalid_q != (cnt_q != '0)))
	`ASSERT_NEVER(a_write_idle, clk, arst_n, we && state_q != DECIDE)
	`ASSERT_IMPL(a_accept, clk, arst_n, s_tvalid && s_tready |=> state_q == SCAN1)
endmodule
`default_nettype wire

// ===== rtl/core/iat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module iat_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
